/* rtl/core/aac_pkg.sv */
// ----------------------------------------------------------------------------
// aac_pkg: shared types and constants for the attitude command block
// Fixed-point widths, command limits and register addresses.
// ----------------------------------------------------------------------------
package aac_pkg;

  localparam int ACCEL_FRAC_BITS = 8;
  localparam int IN_W  = 16;
  localparam int CMD_W = 12;
  localparam int CHK_W = 16;
  localparam int TGT_W = 9;

  // positive tilt denominator magnitude: 49*2^F + 5*32768
  localparam int DW    = ((ACCEL_FRAC_BITS + 6 > 18) ? ACCEL_FRAC_BITS + 6 : 18) + 1;
  localparam int DEN_W = DW + 1;
  // |accel| * 11000
  localparam int NUM_W = 30;
  localparam int Q_W   = 11;
  localparam int CMP_W = (NUM_W > DW + Q_W) ? NUM_W : DW + Q_W;
  localparam int DIV_LAT = Q_W + 2;

  localparam int T_W    = ((ACCEL_FRAC_BITS + 11 > 24) ? ACCEL_FRAC_BITS + 11 : 24) + 2;
  localparam int ERR_W  = 31;
  localparam int PROD_W = 45;
  localparam int YSH    = 24;
  localparam int V_W    = PROD_W - YSH;

  localparam int THRUST_BASE = 1830;
  localparam int THRUST_GAIN = 165;
  localparam int THRUST_MAX  = 2400;
  localparam int THRUST_MIN  = 1700;
  localparam int TILT_NUM    = 11000;
  localparam int DEN_GAIN    = 49;
  localparam int CMD_LIMIT   = 1500;
  localparam int YAW_NUM     = 9321;
  localparam int DEG_TO_RAD_Q24 = 292818;
  localparam int YAW_SAT_V   = 5 * CMD_LIMIT + 5;
  localparam int RECIP5      = 13108;
  localparam logic [CHK_W-1:0] CHK_INIT = 16'hAAAA + 16'h000F;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_YAW_TARGET = 3'd0;

  typedef struct packed {
    logic fault;
    logic neg;
    logic zero;
  } div_ctl_t;

endpackage

/* rtl/core/aac_div.sv */
// ----------------------------------------------------------------------------
// aac_div: pipelined tilt divider
// Restoring division, one quotient bit per stage, with saturation to the
// command limit and sign forcing on a non-positive denominator.
// ----------------------------------------------------------------------------
module aac_div
  import aac_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [NUM_W-1:0]        num_mag_i,
  input  logic [DW-1:0]           den_i,
  input  div_ctl_t                ctl_i,
  output logic signed [CMD_W-1:0] cmd_o
);

  typedef struct packed {
    logic [CMP_W-1:0] rem;
    logic [DW-1:0]    den;
    logic [Q_W-1:0]   quo;
    logic             sat;
    div_ctl_t         ctl;
  } stage_t;

  stage_t st_d [Q_W+1];
  stage_t st_q [Q_W+1];
  logic signed [CMD_W-1:0] cmd_d, cmd_q;

  // quotient of 2^Q_W or more saturates anyway
  always_comb begin
    logic [CMP_W-1:0] dsh;
    st_d[0].rem = CMP_W'(num_mag_i);
    st_d[0].den = den_i;
    st_d[0].quo = '0;
    st_d[0].ctl = ctl_i;
    st_d[0].sat = CMP_W'(num_mag_i) >= CMP_W'({den_i, {Q_W{1'b0}}});
    for (int k = 1; k <= Q_W; k++) begin
      dsh = CMP_W'(st_q[k-1].den) << (Q_W - k);
      st_d[k] = st_q[k-1];
      if (st_q[k-1].rem >= dsh) begin
        st_d[k].rem = st_q[k-1].rem - dsh;
        st_d[k].quo[Q_W-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= Q_W; k++) st_q[k] <= st_d[k];
    end
  end

  always_comb begin
    logic [CMD_W-1:0] mag;
    if (st_q[Q_W].ctl.fault) begin
      mag = st_q[Q_W].ctl.zero ? '0 : CMD_W'(CMD_LIMIT);
    end else if (st_q[Q_W].sat || CMD_W'(st_q[Q_W].quo) > CMD_W'(CMD_LIMIT)) begin
      mag = CMD_W'(CMD_LIMIT);
    end else begin
      mag = CMD_W'(st_q[Q_W].quo);
    end
    cmd_d = st_q[Q_W].ctl.neg ? -signed'(mag) : signed'(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

endmodule

/* rtl/core/accel_to_attitude_command_top.sv */
// ----------------------------------------------------------------------------
// accel_to_attitude_command_top: acceleration to attitude command converter
// Thrust, roll, pitch and yaw commands with saturation and frame checksum.
// ----------------------------------------------------------------------------
// The input is registered in stage a, then passes the divider pipeline and the output register.
// Throughput: one item per cycle while the output is not stalled; the depth is set
// by the two restoring dividers for roll and pitch that run side by side.
// A stalled output holds the whole pipeline in place.
// Reset clears all valid bits and sets the yaw target to zero.
module accel_to_attitude_command_top
  import aac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,  // accel_x, accel_y, accel_z, yaw_angle
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // thrust, roll, pitch, yaw, checksum
  output logic              m_axis_tuser,  // tilt_fault
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic en;
  logic out_valid_q;
  logic signed [TGT_W-1:0] tgt_q;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_YAW_TARGET) begin
      tgt_q <= signed'(pwdata[TGT_W-1:0]);
    end
  end
  assign prdata = (paddr == ADDR_YAW_TARGET) ? 32'({tgt_q}) : '0;

  assign en = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage a: operand preparation
  logic signed [IN_W-1:0] ax, ay, az, psi;
  assign ax  = signed'(s_axis_tdata[15:0]);
  assign ay  = signed'(s_axis_tdata[31:16]);
  assign az  = signed'(s_axis_tdata[47:32]);
  assign psi = signed'(s_axis_tdata[63:48]);

  logic signed [DEN_W-1:0] den;
  logic signed [T_W-1:0]   thr_full, thr_int;
  logic [CMD_W-1:0]        thr_d;
  logic signed [ERR_W-1:0] nerr_d;
  logic [IN_W-1:0]         ax_abs, ay_abs;
  logic [NUM_W-1:0]        numx_d, numy_d;
  div_ctl_t                ctlx_d, ctly_d;
  logic                    fault_d;

  always_comb begin
    den = DEN_W'(DEN_GAIN <<< ACCEL_FRAC_BITS) - DEN_W'(az) * DEN_W'(5);
    fault_d = den[DEN_W-1] || den == '0;
    ax_abs = ax[IN_W-1] ? IN_W'(-ax) : IN_W'(ax);
    ay_abs = ay[IN_W-1] ? IN_W'(-ay) : IN_W'(ay);
    numx_d = NUM_W'(ax_abs) * NUM_W'(TILT_NUM);
    numy_d = NUM_W'(ay_abs) * NUM_W'(TILT_NUM);
    ctlx_d = '{fault: fault_d, neg: !ax[IN_W-1] && ax != '0, zero: ax == '0};
    ctly_d = '{fault: fault_d, neg: !ay[IN_W-1] && ay != '0, zero: ay == '0};
    // negative totals clamp to the minimum, so floor equals truncation here
    thr_full = T_W'(THRUST_BASE <<< ACCEL_FRAC_BITS) - T_W'(az) * T_W'(THRUST_GAIN);
    thr_int  = thr_full >>> ACCEL_FRAC_BITS;
    if (thr_int < T_W'(THRUST_MIN)) begin
      thr_d = CMD_W'(THRUST_MIN);
    end else if (thr_int > T_W'(THRUST_MAX)) begin
      thr_d = CMD_W'(THRUST_MAX);
    end else begin
      thr_d = thr_int[CMD_W-1:0];
    end
    nerr_d = ERR_W'(tgt_q) * ERR_W'(DEG_TO_RAD_Q24) - (ERR_W'(psi) <<< 12);
  end

  logic                    a_valid_q;
  logic [DW-1:0]           den_a_q;
  logic [NUM_W-1:0]        numx_a_q, numy_a_q;
  div_ctl_t                ctlx_a_q, ctly_a_q;
  logic [CMD_W-1:0]        thr_a_q;
  logic                    fault_a_q;
  logic signed [ERR_W-1:0] nerr_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_a_q   <= den[DW-1:0];
      numx_a_q  <= numx_d;
      numy_a_q  <= numy_d;
      ctlx_a_q  <= ctlx_d;
      ctly_a_q  <= ctly_d;
      thr_a_q   <= thr_d;
      fault_a_q <= fault_d;
      nerr_a_q  <= nerr_d;
    end
  end

  // roll and pitch dividers
  logic signed [CMD_W-1:0] roll_div, pitch_div;

  aac_div u_div_roll (
    .clk_i     (clk_i),
    .en_i      (en),
    .num_mag_i (numy_a_q),
    .den_i     (den_a_q),
    .ctl_i     (ctly_a_q),
    .cmd_o     (roll_div)
  );

  aac_div u_div_pitch (
    .clk_i     (clk_i),
    .en_i      (en),
    .num_mag_i (numx_a_q),
    .den_i     (den_a_q),
    .ctl_i     (ctlx_a_q),
    .cmd_o     (pitch_div)
  );

  // yaw: multiply, scale down by 2^24, divide by five through a reciprocal
  logic signed [PROD_W-1:0] prod_b_q;
  logic [V_W-1:0]           pmag_v;
  logic [12:0]              v_c_q;
  logic                     sat_c_q, neg_c_q;
  logic [26:0]              recip_p;
  logic [CMD_W-1:0]         ymag;
  logic signed [CMD_W-1:0]  yaw_d_q;
  logic [PROD_W-1:0]        pabs;

  always_comb begin
    pabs    = prod_b_q[PROD_W-1] ? PROD_W'(-prod_b_q) : PROD_W'(prod_b_q);
    pmag_v  = pabs[PROD_W-1:YSH];
    recip_p = 27'(v_c_q) * 27'(RECIP5);
    ymag    = sat_c_q ? CMD_W'(CMD_LIMIT) : CMD_W'(recip_p[26:16]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_b_q <= PROD_W'(nerr_a_q) * PROD_W'(YAW_NUM);
      v_c_q    <= pmag_v[12:0];
      sat_c_q  <= pmag_v >= V_W'(YAW_SAT_V);
      neg_c_q  <= prod_b_q[PROD_W-1];
      yaw_d_q  <= neg_c_q ? -signed'(ymag) : signed'(ymag);
    end
  end

  // sideband delay lines matched to the divider depth
  logic                    vl_q    [DIV_LAT];
  logic [CMD_W-1:0]        thr_l_q [DIV_LAT];
  logic                    flt_l_q [DIV_LAT];
  logic signed [CMD_W-1:0] yaw_l_q [DIV_LAT-3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) vl_q[i] <= 1'b0;
    end else if (en) begin
      vl_q[0] <= a_valid_q;
      for (int i = 1; i < DIV_LAT; i++) vl_q[i] <= vl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      thr_l_q[0] <= thr_a_q;
      flt_l_q[0] <= fault_a_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        thr_l_q[i] <= thr_l_q[i-1];
        flt_l_q[i] <= flt_l_q[i-1];
      end
      yaw_l_q[0] <= yaw_d_q;
      for (int i = 1; i < DIV_LAT - 3; i++) yaw_l_q[i] <= yaw_l_q[i-1];
    end
  end

  // output register
  logic [CMD_W-1:0]        thr_o_q;
  logic signed [CMD_W-1:0] roll_o_q, pitch_o_q, yaw_o_q;
  logic [CHK_W-1:0]        chk_o_q, chk_d;
  logic                    flt_o_q;

  always_comb begin
    chk_d = CHK_INIT + CHK_W'(thr_l_q[DIV_LAT-1]) + CHK_W'(roll_div) + CHK_W'(pitch_div)
          + CHK_W'(yaw_l_q[DIV_LAT-4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vl_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      thr_o_q   <= thr_l_q[DIV_LAT-1];
      roll_o_q  <= roll_div;
      pitch_o_q <= pitch_div;
      yaw_o_q   <= yaw_l_q[DIV_LAT-4];
      chk_o_q   <= chk_d;
      flt_o_q   <= flt_l_q[DIV_LAT-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {chk_o_q, yaw_o_q, pitch_o_q, roll_o_q, thr_o_q};
  assign m_axis_tuser  = flt_o_q;

  a_fault_forced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && flt_o_q |->
      (roll_o_q == CMD_W'(CMD_LIMIT) || roll_o_q == -CMD_W'(CMD_LIMIT) || roll_o_q == '0) &&
      (pitch_o_q == CMD_W'(CMD_LIMIT) || pitch_o_q == -CMD_W'(CMD_LIMIT) || pitch_o_q == '0))
    else $error("tilt fault without forced roll/pitch");

  a_thrust_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> thr_o_q >= CMD_W'(THRUST_MIN) && thr_o_q <= CMD_W'(THRUST_MAX))
    else $error("thrust out of range");

  a_cmd_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> roll_o_q >= -CMD_W'(CMD_LIMIT) && roll_o_q <= CMD_W'(CMD_LIMIT) &&
      yaw_o_q >= -CMD_W'(CMD_LIMIT) && yaw_o_q <= CMD_W'(CMD_LIMIT))
    else $error("roll or yaw out of range");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(chk_o_q) && out_valid_q)
    else $error("output changed during stall");

endmodule

/* tb/accel_to_attitude_command_top_test.sv */
// ----------------------------------------------------------------------------
// accel_to_attitude_command_top_test: self-checking bench for the attitude
// command converter
// Drives acceleration/yaw items with random gaps, stalls the result side,
// writes the yaw target over APB between phases and checks every command,
// checksum and tilt fault against an in-bench integer predictor.
// ----------------------------------------------------------------------------
module accel_to_attitude_command_top_test;
  import aac_pkg::*;

  typedef struct {
    logic [11:0] thrust;
    logic [11:0] roll;
    logic [11:0] pitch;
    logic [11:0] yaw;
    logic [15:0] chk;
    logic        fault;
  } cmd_set_t;

  class command_scoreboard;
    cmd_set_t pending[$];
    int       n_err;
    logic signed [8:0] tgt_deg;

    function longint sat(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint tilt(longint acc, longint den, bit fault);
      longint num;
      num = -acc * 11000;
      if (fault) begin
        if (num > 0) return CMD_LIMIT;
        if (num < 0) return -CMD_LIMIT;
        return 0;
      end
      return sat(num / den, -CMD_LIMIT, CMD_LIMIT);
    endfunction

    function void note_input(logic [63:0] d);
      longint ax, ay, az, psi, sc, thr, den, rl, pt, err, yw;
      logic [15:0] sum;
      cmd_set_t c;
      ax  = longint'($signed(d[15:0]));
      ay  = longint'($signed(d[31:16]));
      az  = longint'($signed(d[47:32]));
      psi = longint'($signed(d[63:48]));
      sc  = 256;
      thr = sat((1830 * sc - 165 * az) / sc, 1700, 2400);
      den = 49 * sc - 5 * az;
      c.fault = den <= 0;
      rl  = tilt(ay, den, c.fault);
      pt  = tilt(ax, den, c.fault);
      err = psi * 4096 - longint'(tgt_deg) * 292818;
      yw  = sat((-err * 9321) / (longint'(5) << 24), -CMD_LIMIT, CMD_LIMIT);
      sum = 16'(thr + pt + rl + yw + 15 + 'hAAAA);
      c.thrust = 12'(thr);
      c.roll = 12'(rl);
      c.pitch = 12'(pt);
      c.yaw = 12'(yw);
      c.chk = sum;
      pending.push_back(c);
    endfunction

    function void check_result(logic [63:0] d, logic f);
      cmd_set_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        n_err++;
        return;
      end
      e = pending.pop_front();
      if (d[11:0] !== e.thrust) begin
        $error("thrust_cmd exp %0d got %0d", e.thrust, d[11:0]); n_err++;
      end
      if (d[23:12] !== e.roll) begin
        $error("roll_cmd exp %h got %h", e.roll, d[23:12]); n_err++;
      end
      if (d[35:24] !== e.pitch) begin
        $error("pitch_cmd exp %h got %h", e.pitch, d[35:24]); n_err++;
      end
      if (d[47:36] !== e.yaw) begin
        $error("yaw_cmd exp %h got %h", e.yaw, d[47:36]); n_err++;
      end
      if (d[63:48] !== e.chk) begin
        $error("frame_checksum exp %h got %h", e.chk, d[63:48]); n_err++;
      end
      if (f !== e.fault) begin
        $error("tilt_fault exp %b got %b", e.fault, f); n_err++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [63:0] s_axis_tdata;  // accel_x, accel_y, accel_z, yaw_angle
  logic [63:0] m_axis_tdata;  // thrust, roll, pitch, yaw, checksum
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  command_scoreboard cmd_sb;
  int  idle_pct, hold_off, quiet_cycles;
  bit  stim_done;

  accel_to_attitude_command_top DUT (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic write_target(logic signed [8:0] deg);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_YAW_TARGET;
    pwdata <= 32'(deg);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    cmd_sb.tgt_deg = deg;
  endtask

  task automatic send_item(logic [15:0] ax, ay, az, psi);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {psi, az, ay, ax};
    do @(posedge clk_i); while (!s_axis_tready);
    cmd_sb.note_input({psi, az, ay, ax});
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (cmd_sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // pick signed 16-bit values, favoring the region where dividers matter
  function automatic logic [15:0] rnd_accel();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(6000)) - 3000);
      2: return 16'($signed($urandom_range(200)) + 2408);
      default: return 16'($signed($urandom_range(1000)) - 500);
    endcase
  endfunction

  // result side: random stall, one long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      cmd_sb.check_result(m_axis_tdata, m_axis_tuser);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic signed [8:0] targets[6];
    logic [15:0] edges[6];
    cmd_sb = new();
    cmd_sb.tgt_deg = 0;
    targets = '{9'sd180, -9'sd180, 9'sd255, -9'sd256, 9'sd45, 9'sd0};
    edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd2508, 16'd2509};
    idle_pct = 33; hold_off = 0; quiet_cycles = 0; stim_done = 0;
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    // directed: field extremes, tilt boundary (D>0 at az=2508, D<0 at az=2509), zero numerators
    foreach (edges[i]) begin
      send_item(edges[i], edges[5 - i], edges[i], edges[(i + 2) % 6]);
      send_item(edges[(i + 1) % 6], edges[i], 16'd2509, edges[i]);
    end
    send_item(16'h0000, 16'h0000, 16'd3000, 16'h0000);
    send_item(16'h0100, 16'hFF00, 16'hF000, 16'h0C90);
    drain();
    foreach (targets[t]) begin
      write_target(targets[t]);
      idle_pct = (t == 2) ? 0 : 33;
      for (int n = 0; n < 135; n++) begin
        if (t == 3 && n == 10) hold_off <= 300;
        send_item(rnd_accel(), rnd_accel(), rnd_accel(), 16'($urandom));
      end
      drain();
    end
    stim_done = 1;
    if (cmd_sb.n_err == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
